// ===== design/tle_pkg.sv =====
package tle_pkg;

  // Result kinds
  localparam logic [1:0] KIND_EDIT   = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  // Escape sequence phases
  localparam logic [1:0] ESC_NONE    = 2'd0;
  localparam logic [1:0] ESC_SEEN    = 2'd1;
  localparam logic [1:0] ESC_BRACKET = 2'd2;
  localparam logic [1:0] ESC_THREE   = 2'd3;

  // Received byte codes
  localparam logic [7:0] BYTE_CTRL_C  = 8'd3;
  localparam logic [7:0] BYTE_BS      = 8'd8;
  localparam logic [7:0] BYTE_ENTER   = 8'd10;
  localparam logic [7:0] BYTE_ESC     = 8'd27;
  localparam logic [7:0] BYTE_DEL     = 8'd127;
  localparam logic [7:0] BYTE_LBRACK  = 8'h5B; // '['
  localparam logic [7:0] BYTE_FWD     = 8'h43; // 'C'
  localparam logic [7:0] BYTE_BACK    = 8'h44; // 'D'
  localparam logic [7:0] BYTE_THREE   = 8'h33; // '3'
  localparam logic [7:0] BYTE_TILDE   = 8'h7E; // '~'

  // Command broadcast to every cell of the line
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [6:0]  pos;
  } cell_cmd_t;

endpackage

// ===== design/tle_cell.sv =====
module tle_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  tle_pkg::cell_cmd_t cmd,
  input  logic [7:0]        new_char,
  input  logic [7:0]        left_char,
  input  logic [7:0]        right_char,
  output logic [7:0]        char_q
);
  import tle_pkg::*;

  localparam logic [6:0] IDX_W = 7'(IDX);

  logic [7:0] char_r;
  logic [7:0] char_nxt;

  // Pick this cell's next character from the command and its neighbors
  always_comb begin
    char_nxt = char_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (IDX_W > cmd.pos) begin
          char_nxt = left_char;
        end else if (IDX_W == cmd.pos) begin
          char_nxt = new_char;
        end
      end
      CELL_REMOVE: begin
        if (IDX_W >= cmd.pos) begin
          char_nxt = right_char;
        end
      end
      CELL_SHIFT: begin
        char_nxt = right_char;
      end
      default: begin
        char_nxt = char_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;

endmodule

// ===== design/terminal_line_editor_core.sv =====
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_ready    | in_rx_byte
// out_     | output    | out_valid / out_ready  | out_kind, out_char_value, out_cursor,
//          |           |                        | out_length, out_dropped, out_last
//
// An edit, cursor move, escape byte or Ctrl-C loads one result.
// Enter on an n-character line shifts the line out of cell 0 of the cell chain,
// one character per cycle while the output register can load.
// Reset (rst_n low, synchronous) clears cursor, length, escape phase and control;
// the cell contents are not cleared. A stalled result holds the output register
// and the chain; a new byte is taken only when the output register can load.
module terminal_line_editor_core #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_char_value,
  output logic [6:0] out_cursor,
  output logic [6:0] out_length,
  output logic       out_dropped,
  output logic       out_last
);
  import tle_pkg::*;

  localparam logic [6:0] CAP_W = 7'(LINE_CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] esc_r, esc_nxt;
  logic [6:0] cursor_r, cursor_nxt;
  logic [6:0] length_r, length_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic [6:0] out_cursor_r, out_cursor_nxt;
  logic [6:0] out_length_r, out_length_nxt;
  logic       out_dropped_r, out_dropped_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_free;
  logic       in_acc;
  cell_cmd_t  cmd;
  logic [7:0] cell_char [LINE_CAPACITY];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  // Decode the byte, update cursor and length, command the chain
  always_comb begin
    logic       status;
    logic       drop;
    status          = 1'b0;
    drop            = 1'b0;
    state_nxt       = state_r;
    esc_nxt         = esc_r;
    cursor_nxt      = cursor_r;
    length_nxt      = length_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_char_nxt    = out_char_r;
    out_cursor_nxt  = out_cursor_r;
    out_length_nxt  = out_length_r;
    out_dropped_nxt = out_dropped_r;
    out_last_nxt    = out_last_r;
    cmd.op          = CELL_HOLD;
    cmd.pos         = cursor_r;

    if (in_acc) begin
      unique case (esc_r)
        ESC_SEEN: begin
          esc_nxt = (in_rx_byte == BYTE_LBRACK) ? ESC_BRACKET : ESC_NONE;
          status  = 1'b1;
        end
        ESC_BRACKET: begin
          esc_nxt = ESC_NONE;
          status  = 1'b1;
          if (in_rx_byte == BYTE_FWD) begin
            if (cursor_r < length_r) begin
              cursor_nxt = cursor_r + 7'd1;
            end
          end else if (in_rx_byte == BYTE_BACK) begin
            if (cursor_r != 7'd0) begin
              cursor_nxt = cursor_r - 7'd1;
            end
          end else if (in_rx_byte == BYTE_THREE) begin
            esc_nxt = ESC_THREE;
          end
        end
        ESC_THREE: begin
          esc_nxt = ESC_NONE;
          status  = 1'b1;
          if (in_rx_byte == BYTE_TILDE && cursor_r < length_r) begin
            cmd.op     = CELL_REMOVE;
            cmd.pos    = cursor_r;
            length_nxt = length_r - 7'd1;
          end
        end
        default: begin
          if (in_rx_byte == BYTE_ESC) begin
            esc_nxt = ESC_SEEN;
            status  = 1'b1;
          end else if (in_rx_byte == BYTE_ENTER) begin
            cursor_nxt = 7'd0;
            length_nxt = 7'd0;
            if (length_r == 7'd0) begin
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = KIND_EMPTY;
              out_char_nxt    = 8'd0;
              out_cursor_nxt  = 7'd0;
              out_length_nxt  = 7'd0;
              out_dropped_nxt = 1'b0;
              out_last_nxt    = 1'b1;
            end else begin
              cnt_nxt   = length_r;
              state_nxt = S_EMIT;
            end
          end else if (in_rx_byte == BYTE_CTRL_C) begin
            cursor_nxt      = 7'd0;
            length_nxt      = 7'd0;
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = KIND_CANCEL;
            out_char_nxt    = 8'd0;
            out_cursor_nxt  = 7'd0;
            out_length_nxt  = 7'd0;
            out_dropped_nxt = 1'b0;
            out_last_nxt    = 1'b1;
          end else if (in_rx_byte == BYTE_BS || in_rx_byte == BYTE_DEL) begin
            status = 1'b1;
            if (cursor_r != 7'd0) begin
              cursor_nxt = cursor_r - 7'd1;
              length_nxt = length_r - 7'd1;
              cmd.op     = CELL_REMOVE;
              cmd.pos    = cursor_r - 7'd1;
            end
          end else begin
            status = 1'b1;
            if (length_r >= CAP_W || cursor_r > length_r) begin
              drop = 1'b1;
            end else begin
              cmd.op     = CELL_INSERT;
              cmd.pos    = cursor_r;
              cursor_nxt = cursor_r + 7'd1;
              length_nxt = length_r + 7'd1;
            end
          end
        end
      endcase

      // Load the edit status result
      if (status) begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = KIND_EDIT;
        out_char_nxt    = 8'd0;
        out_cursor_nxt  = cursor_nxt;
        out_length_nxt  = length_nxt;
        out_dropped_nxt = drop;
        out_last_nxt    = 1'b1;
      end
    end

    // Shift the line out of cell 0, one character per free output slot
    if (state_r == S_EMIT && out_free) begin
      out_valid_nxt   = 1'b1;
      out_kind_nxt    = KIND_CHAR;
      out_char_nxt    = cell_char[0];
      out_cursor_nxt  = 7'd0;
      out_length_nxt  = 7'd0;
      out_dropped_nxt = 1'b0;
      out_last_nxt    = (cnt_r == 7'd1);
      cmd.op          = CELL_SHIFT;
      cnt_nxt         = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        state_nxt = S_IDLE;
      end
    end
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      esc_r       <= ESC_NONE;
      cursor_r    <= 7'd0;
      length_r    <= 7'd0;
      cnt_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      cursor_r    <= cursor_nxt;
      length_r    <= length_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r    <= out_kind_nxt;
    out_char_r    <= out_char_nxt;
    out_cursor_r  <= out_cursor_nxt;
    out_length_r  <= out_length_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Chain of character cells, each linked to both neighbors
  for (genvar gi = 0; gi < LINE_CAPACITY; gi++) begin : g_cell
    logic [7:0] left_char;
    logic [7:0] right_char;
    if (gi == 0) begin : g_first
      assign left_char = 8'd0;
    end else begin : g_inner_l
      assign left_char = cell_char[gi-1];
    end
    if (gi == LINE_CAPACITY - 1) begin : g_last
      assign right_char = 8'd0;
    end else begin : g_inner_r
      assign right_char = cell_char[gi+1];
    end
    tle_cell #(
      .IDX(gi)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_char   (in_rx_byte),
      .left_char  (left_char),
      .right_char (right_char),
      .char_q     (cell_char[gi])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_char_value = out_char_r;
  assign out_cursor     = out_cursor_r;
  assign out_length     = out_length_r;
  assign out_dropped    = out_dropped_r;
  assign out_last       = out_last_r;

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import tle_pkg::*;

  localparam int LINE_CAP       = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [6:0] cursor;
    logic [6:0] length;
    logic       dropped;
    logic       last;
  } line_result_t;

  // Line editor scoreboard: mirrors the editor state and holds the results it still owes
  class line_editor_sb;
    line_result_t owed_q[$];
    logic [7:0]   line_buf [LINE_CAP];
    logic [6:0]   cur_pos;
    logic [6:0]   line_len;
    logic [1:0]   esc_phase;
    int           mismatches;

    function new();
      cur_pos    = '0;
      line_len   = '0;
      esc_phase  = ESC_NONE;
      mismatches = 0;
    endfunction

    function void owe(logic [1:0] kind, logic [7:0] ch, logic drop, logic last);
      line_result_t r;
      r.kind    = kind;
      r.ch      = ch;
      r.cursor  = cur_pos;
      r.length  = line_len;
      r.dropped = drop;
      r.last    = last;
      owed_q.push_back(r);
    endfunction

    // Close the gap left by the character at pos
    function void remove_char(logic [6:0] pos);
      int i;
      if (pos < line_len) begin
        for (i = pos; i + 1 < line_len; i++) line_buf[i] = line_buf[i + 1];
        line_len = line_len - 7'd1;
      end
    endfunction

    // Apply one accepted byte and queue the results it causes
    function void note_byte(logic [7:0] b);
      logic drop;
      int   n;
      int   i;
      drop = 1'b0;
      case (esc_phase)
        ESC_SEEN: begin
          esc_phase = (b == BYTE_LBRACK) ? ESC_BRACKET : ESC_NONE;
        end
        ESC_BRACKET: begin
          esc_phase = ESC_NONE;
          if (b == BYTE_FWD) begin
            if (cur_pos < line_len) cur_pos = cur_pos + 7'd1;
          end else if (b == BYTE_BACK) begin
            if (cur_pos > 0) cur_pos = cur_pos - 7'd1;
          end else if (b == BYTE_THREE) begin
            esc_phase = ESC_THREE;
          end
        end
        ESC_THREE: begin
          esc_phase = ESC_NONE;
          if (b == BYTE_TILDE) remove_char(cur_pos);
        end
        default: begin
          if (b == BYTE_ESC) begin
            esc_phase = ESC_SEEN;
          end else if (b == BYTE_ENTER) begin
            n        = line_len;
            cur_pos  = '0;
            line_len = '0;
            if (n == 0) owe(KIND_EMPTY, 8'd0, 1'b0, 1'b1);
            for (i = 0; i < n; i++) owe(KIND_CHAR, line_buf[i], 1'b0, i + 1 == n);
            return;
          end else if (b == BYTE_CTRL_C) begin
            cur_pos  = '0;
            line_len = '0;
            owe(KIND_CANCEL, 8'd0, 1'b0, 1'b1);
            return;
          end else if (b == BYTE_BS || b == BYTE_DEL) begin
            if (cur_pos > 0) begin
              cur_pos = cur_pos - 7'd1;
              remove_char(cur_pos);
            end
          end else if (line_len >= LINE_CAP || cur_pos > line_len) begin
            drop = 1'b1;
          end else begin
            for (i = line_len; i > cur_pos; i--) line_buf[i] = line_buf[i - 1];
            line_buf[cur_pos] = b;
            cur_pos  = cur_pos + 7'd1;
            line_len = line_len + 7'd1;
          end
        end
      endcase
      owe(KIND_EDIT, 8'd0, drop, 1'b1);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function string fmt(line_result_t r);
      return $sformatf("kind=%0d char=%0d cursor=%0d length=%0d drop=%0d last=%0d",
                       r.kind, r.ch, r.cursor, r.length, r.dropped, r.last);
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check_result(line_result_t got);
      line_result_t exp;
      if (owed_q.size() == 0) begin
        report({"unexpected result: ", fmt(got)});
        return;
      end
      exp = owed_q.pop_front();
      if (got.kind !== exp.kind || got.ch !== exp.ch || got.cursor !== exp.cursor ||
          got.length !== exp.length || got.dropped !== exp.dropped || got.last !== exp.last)
        report({"mismatch: exp ", fmt(exp), " | got ", fmt(got)});
    endfunction

    // Count every result that never arrived
    function void flush_owed();
      line_result_t exp;
      while (owed_q.size() > 0) begin
        exp = owed_q.pop_front();
        report({"missing result: ", fmt(exp)});
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_kind;
  logic [7:0] out_char_value;
  logic [6:0] out_cursor;
  logic [6:0] out_length;
  logic       out_dropped;
  logic       out_last;

  line_editor_sb sb;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            bytes_sent;
  int            quiet_cycles;

  terminal_line_editor_core #(
    .LINE_CAPACITY(LINE_CAP)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_char_value(out_char_value),
    .out_cursor    (out_cursor),
    .out_length    (out_length),
    .out_dropped   (out_dropped),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every result transaction
  always @(posedge clk) begin
    line_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind    = out_kind;
      got.ch      = out_char_value;
      got.cursor  = out_cursor;
      got.length  = out_length;
      got.dropped = out_dropped;
      got.last    = out_last;
      sb.check_result(got);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Present one byte, hold it until accepted, then predict its results
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_csi(input logic [7:0] final_b);
    send_byte(BYTE_ESC);
    send_byte(BYTE_LBRACK);
    send_byte(final_b);
  endtask

  task automatic send_delete();
    send_csi(BYTE_THREE);
    send_byte(BYTE_TILDE);
  endtask

  // Draw a byte that the editor inserts as text
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == BYTE_CTRL_C || b == BYTE_BS || b == BYTE_ENTER || b == BYTE_ESC ||
           b == BYTE_DEL);
    return b;
  endfunction

  // Mostly well-formed edits with random content, some noise and broken sequences
  task automatic run_random(input int count);
    int target;
    int pick;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_byte(text_byte());
      else if (pick < 55) send_csi(BYTE_FWD);
      else if (pick < 65) send_csi(BYTE_BACK);
      else if (pick < 73) send_delete();
      else if (pick < 83) send_byte($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
      else if (pick < 90) send_byte(BYTE_ENTER);
      else if (pick < 93) send_byte(BYTE_CTRL_C);
      else begin
        case ($urandom_range(0, 3))
          0: send_byte(8'($urandom_range(0, 255)));
          1: begin
            send_byte(BYTE_ESC);
            send_byte(8'($urandom_range(0, 255)));
          end
          2: begin
            send_byte(BYTE_ESC);
            send_byte(BYTE_LBRACK);
            send_byte(8'($urandom_range(0, 255)));
          end
          default: begin
            send_byte(BYTE_ESC);
            send_byte(BYTE_LBRACK);
            send_byte(BYTE_THREE);
            send_byte(8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
  endtask

  // Fill the line to capacity, partly mid-line, overflow it, then enter it
  task automatic fill_line();
    while (sb.esc_phase != ESC_NONE) send_byte(8'h78);
    while (sb.line_len < 40) send_byte(text_byte());
    repeat (3) send_csi(BYTE_BACK);
    while (sb.line_len < LINE_CAP) send_byte(text_byte());
    repeat (2) send_byte(text_byte());
    send_csi(BYTE_FWD);
    send_byte(BYTE_ENTER);
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = 8'd0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extreme bytes, Enter on a non-empty and an empty line
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(BYTE_ENTER);
    send_byte(BYTE_ENTER);
    // Edges: backspace and back at start, forward and delete at end
    send_byte(BYTE_BS);
    send_csi(BYTE_BACK);
    send_byte(8'h78);
    send_byte(8'h79);
    send_csi(BYTE_FWD);
    send_delete();
    // Move back, erase left with DEL, delete at cursor
    send_csi(BYTE_BACK);
    send_byte(BYTE_DEL);
    send_delete();
    // Enter and Ctrl-C swallowed by broken sequences
    send_byte(BYTE_ESC);
    send_byte(BYTE_ENTER);
    send_byte(8'h71);
    send_byte(BYTE_ESC);
    send_byte(BYTE_LBRACK);
    send_byte(BYTE_CTRL_C);
    // Cancel a non-empty line
    send_byte(BYTE_CTRL_C);

    run_random(20);
    send_idle_pct = 46;
    run_random(20);
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    run_random(20);
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    fill_line();
    run_random(10);

    // Drain: wait for every owed result, then let the pipe settle
    in_valid <= 1'b0;
    while (sb.owed_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_owed();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
